FILE: rtl/btb_pkg.sv
// Shared types, widths, register indexes and reset values for the border trim
// bounding box block. No dependencies; every other file in rtl/ uses it.
`timescale 1ns / 1ps
`default_nettype none

package btb_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W      = 8;
    localparam int EDGE_W     = 4;
    localparam int SIZE_W     = 13;
    localparam int CROP_LO_W  = 12;
    localparam int CROP_HI_W  = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    // Default frame size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Largest value a size register can hold
    localparam int SIZE_REG_MAX = (1 << SIZE_W) - 1;

    typedef logic [PIX_W-1:0]      t_pixel;
    typedef logic [EDGE_W-1:0]     t_edge_en;
    typedef logic [SIZE_W-1:0]     t_size;
    typedef logic [CROP_LO_W-1:0]  t_crop_lo;
    typedef logic [CROP_HI_W-1:0]  t_crop_hi;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 8'd0,
        CFG_EDGE_EN   = 8'd1,
        CFG_WIDTH     = 8'd2,
        CFG_HEIGHT    = 8'd3
    } t_cfg_reg;

    // Edge enable bit positions
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;

    // Register reset values
    localparam t_pixel   THRESHOLD_RST = 8'd0;
    localparam t_edge_en EDGE_EN_RST   = 4'hF;
    localparam t_size    WIDTH_RST     = 13'd640;
    localparam t_size    HEIGHT_RST    = 13'd480;

    // Frame status from the tracker to the box stage
    typedef struct packed {
        logic frame_done;   // this pixel closes the frame
        logic any_bright;   // content seen in the frame, this pixel included
    } t_trk_flags;

endpackage

`default_nettype wire

FILE: rtl/btb_if.sv
// Valid/ready channel interfaces: pixel input, crop box output, register writes.
// Depends on btb_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface btb_pix_if;
    logic              valid;
    logic              ready;
    btb_pkg::t_pixel   gray_pixel;

    modport source (output valid, output gray_pixel, input ready);
    modport sink   (input valid, input gray_pixel, output ready);
endinterface

interface btb_box_if;
    logic              valid;
    logic              ready;
    btb_pkg::t_crop_lo crop_left;
    btb_pkg::t_crop_lo crop_top;
    btb_pkg::t_crop_hi crop_right;
    btb_pkg::t_crop_hi crop_bottom;
    logic              was_trimmed;

    modport source (output valid, output crop_left, output crop_top, output crop_right,
                    output crop_bottom, output was_trimmed, input ready);
    modport sink   (input valid, input crop_left, input crop_top, input crop_right,
                    input crop_bottom, input was_trimmed, output ready);
endinterface

interface btb_cfg_if;
    logic               valid;
    logic               ready;
    btb_pkg::t_cfg_idx  index;
    btb_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/btb_cfg.sv
// Configuration registers and frame size clamping.
// Depends on btb_pkg and btb_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module btb_cfg #(
    parameter int MAX_WIDTH  = btb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btb_pkg::MAX_HEIGHT_DEF,
    parameter int COL_W      = 12,
    parameter int ROW_W      = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    btb_cfg_if.sink              i_cfg,
    output btb_pkg::t_pixel      o_threshold,
    output btb_pkg::t_edge_en    o_edge_en,
    output logic [COL_W:0]       o_frame_w,
    output logic [ROW_W:0]       o_frame_h,
    output logic [COL_W-1:0]     o_last_col,
    output logic [ROW_W-1:0]     o_last_row
);

    // A size limit above what the register can hold never binds
    localparam int LIM_W = (MAX_WIDTH  > btb_pkg::SIZE_REG_MAX) ? btb_pkg::SIZE_REG_MAX
                                                                : MAX_WIDTH;
    localparam int LIM_H = (MAX_HEIGHT > btb_pkg::SIZE_REG_MAX) ? btb_pkg::SIZE_REG_MAX
                                                                : MAX_HEIGHT;

    btb_pkg::t_pixel   r_threshold;
    btb_pkg::t_edge_en r_edge_en;
    btb_pkg::t_size    r_width;
    btb_pkg::t_size    r_height;

    assign i_cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= btb_pkg::THRESHOLD_RST;
            r_edge_en   <= btb_pkg::EDGE_EN_RST;
            r_width     <= btb_pkg::WIDTH_RST;
            r_height    <= btb_pkg::HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                btb_pkg::CFG_THRESHOLD: r_threshold <= btb_pkg::t_pixel'(i_cfg.data);
                btb_pkg::CFG_EDGE_EN:   r_edge_en   <= btb_pkg::t_edge_en'(i_cfg.data);
                btb_pkg::CFG_WIDTH:     r_width     <= btb_pkg::t_size'(i_cfg.data);
                btb_pkg::CFG_HEIGHT:    r_height    <= btb_pkg::t_size'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, large values saturate to the limit
    always_comb begin
        if (r_width == '0) begin
            o_frame_w = (COL_W+1)'(1);
        end else if (r_width > btb_pkg::t_size'(LIM_W)) begin
            o_frame_w = (COL_W+1)'(LIM_W);
        end else begin
            o_frame_w = (COL_W+1)'(r_width);
        end

        if (r_height == '0) begin
            o_frame_h = (ROW_W+1)'(1);
        end else if (r_height > btb_pkg::t_size'(LIM_H)) begin
            o_frame_h = (ROW_W+1)'(LIM_H);
        end else begin
            o_frame_h = (ROW_W+1)'(r_height);
        end
    end

    assign o_last_col  = COL_W'(o_frame_w - (COL_W+1)'(1));
    assign o_last_row  = ROW_W'(o_frame_h - (ROW_W+1)'(1));
    assign o_threshold = r_threshold;
    assign o_edge_en   = r_edge_en;

endmodule

`default_nettype wire

FILE: rtl/btb_track.sv
// Raster position counters and bright pixel extent trackers.
// Depends on btb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btb_track #(
    parameter int COL_W = 12,
    parameter int ROW_W = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  btb_pkg::t_pixel      i_pixel,
    input  btb_pkg::t_pixel      i_threshold,
    input  wire [COL_W-1:0]      i_last_col,
    input  wire [ROW_W-1:0]      i_last_row,
    output btb_pkg::t_trk_flags  o_flags,
    output logic [COL_W-1:0]     o_min_col,
    output logic [COL_W-1:0]     o_max_col,
    output logic [ROW_W-1:0]     o_min_row,
    output logic [ROW_W-1:0]     o_max_row
);

    logic [COL_W-1:0] r_col, r_min_col, r_max_col;
    logic [ROW_W-1:0] r_row, r_min_row, r_max_row;
    logic             r_any;

    logic [COL_W-1:0] n_min_col, n_max_col;
    logic [ROW_W-1:0] n_min_row, n_max_row;
    logic             n_any;
    logic             bright, last_col, last_row;

    // Extents including the current pixel
    always_comb begin
        bright    = i_pixel > i_threshold;
        n_min_col = (bright && (r_col < r_min_col)) ? r_col : r_min_col;
        n_max_col = (bright && (r_col > r_max_col)) ? r_col : r_max_col;
        n_min_row = (bright && (r_row < r_min_row)) ? r_row : r_min_row;
        n_max_row = (bright && (r_row > r_max_row)) ? r_row : r_max_row;
        n_any     = r_any | bright;
        // >= so that a size shrunk mid-frame ends the row or frame here
        last_col  = r_col >= i_last_col;
        last_row  = r_row >= i_last_row;
    end

    assign o_flags.frame_done = last_col & last_row;
    assign o_flags.any_bright = n_any;
    assign o_min_col = n_min_col;
    assign o_max_col = n_max_col;
    assign o_min_row = n_min_row;
    assign o_max_row = n_max_row;

    // Position and tracker update; clean state after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (i_step) begin
            if (last_col && last_row) begin
                r_col     <= '0;
                r_row     <= '0;
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
                r_any     <= 1'b0;
            end else begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_any     <= n_any;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/btb_box.sv
// Crop box assembly from the frame extents and the result output register.
// Depends on btb_pkg and btb_box_if.
`timescale 1ns / 1ps
`default_nettype none

module btb_box #(
    parameter int COL_W = 12,
    parameter int ROW_W = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  btb_pkg::t_trk_flags  i_flags,
    input  wire [COL_W-1:0]      i_min_col,
    input  wire [COL_W-1:0]      i_max_col,
    input  wire [ROW_W-1:0]      i_min_row,
    input  wire [ROW_W-1:0]      i_max_row,
    input  btb_pkg::t_edge_en    i_edge_en,
    input  wire [COL_W:0]        i_frame_w,
    input  wire [ROW_W:0]        i_frame_h,
    output logic                 o_advance,
    btb_box_if.source            o_box
);

    logic [COL_W-1:0] left;
    logic [COL_W:0]   right;
    logic [ROW_W-1:0] top;
    logic [ROW_W:0]   bottom;
    logic             trimmed;

    logic              r_vld;
    btb_pkg::t_crop_lo r_left, r_top;
    btb_pkg::t_crop_hi r_right, r_bottom;
    logic              r_trimmed;

    // Trim enabled edges; fall back to the full frame for an empty box
    always_comb begin
        left   = (i_flags.any_bright && i_edge_en[btb_pkg::EDGE_LEFT])   ? i_min_col : '0;
        right  = (i_flags.any_bright && i_edge_en[btb_pkg::EDGE_RIGHT])
               ? ((COL_W+1)'(i_max_col) + (COL_W+1)'(1)) : i_frame_w;
        top    = (i_flags.any_bright && i_edge_en[btb_pkg::EDGE_TOP])    ? i_min_row : '0;
        bottom = (i_flags.any_bright && i_edge_en[btb_pkg::EDGE_BOTTOM])
               ? ((ROW_W+1)'(i_max_row) + (ROW_W+1)'(1)) : i_frame_h;
        trimmed = i_flags.any_bright && (right > (COL_W+1)'(left))
                                     && (bottom > (ROW_W+1)'(top));
        if (!trimmed) begin
            left   = '0;
            right  = i_frame_w;
            top    = '0;
            bottom = i_frame_h;
        end
    end

    // Only a frame's last pixel has to wait for a free or draining output slot
    assign o_advance = !i_flags.frame_done || !r_vld || o_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_step && i_flags.frame_done) begin
            r_vld <= 1'b1;
        end else if (o_box.ready) begin
            r_vld <= 1'b0;
        end
    end

    // Result payload, loaded at the last pixel of a frame
    always_ff @(posedge i_clk) begin
        if (i_step && i_flags.frame_done) begin
            r_left    <= btb_pkg::t_crop_lo'(left);
            r_top     <= btb_pkg::t_crop_lo'(top);
            r_right   <= btb_pkg::t_crop_hi'(right);
            r_bottom  <= btb_pkg::t_crop_hi'(bottom);
            r_trimmed <= trimmed;
        end
    end

    assign o_box.valid       = r_vld;
    assign o_box.crop_left   = r_left;
    assign o_box.crop_top    = r_top;
    assign o_box.crop_right  = r_right;
    assign o_box.crop_bottom = r_bottom;
    assign o_box.was_trimmed = r_trimmed;

endmodule

`default_nettype wire

FILE: rtl/border_trim_bounding_box_core.sv
// Border trim bounding box: takes one gray pixel per clock, in raster order, and
// after the last pixel of each frame delivers one crop box (left/top inclusive,
// right/bottom exclusive) around all pixels brighter than the threshold. Each
// pixel goes through an input register and one tracker update; the box is loaded
// into the output register as the frame's last pixel leaves the input register,
// and pixels keep streaming at one per clock while the box waits to be taken. Only
// the last pixel of the next frame waits until the previous box has been taken.
// The rate is set by the combinational position and extent update. Configuration
// is to be written only between frames while the block is idle.
// Depends on btb_pkg, btb_if, btb_cfg, btb_track and btb_box.
`timescale 1ns / 1ps
`default_nettype none

module border_trim_bounding_box_core #(
    parameter int MAX_WIDTH  = btb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btb_pkg::MAX_HEIGHT_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    btb_cfg_if.sink    i_cfg,
    btb_pix_if.sink    i_pix,
    btb_box_if.source  o_box
);

    // Counter widths; the 13-bit size registers cap the useful range
    localparam int COL_W = ($clog2(MAX_WIDTH)  > btb_pkg::SIZE_W) ? btb_pkg::SIZE_W
                                                                  : $clog2(MAX_WIDTH);
    localparam int ROW_W = ($clog2(MAX_HEIGHT) > btb_pkg::SIZE_W) ? btb_pkg::SIZE_W
                                                                  : $clog2(MAX_HEIGHT);

    btb_pkg::t_pixel     threshold;
    btb_pkg::t_edge_en   edge_en;
    logic [COL_W:0]      frame_w;
    logic [ROW_W:0]      frame_h;
    logic [COL_W-1:0]    last_col, min_col, max_col;
    logic [ROW_W-1:0]    last_row, min_row, max_row;
    btb_pkg::t_trk_flags flags;
    logic                advance, step;

    btb_pkg::t_pixel     r_pix;
    logic                r_pix_vld;

    btb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_threshold (threshold),
        .o_edge_en   (edge_en),
        .o_frame_w   (frame_w),
        .o_frame_h   (frame_h),
        .o_last_col  (last_col),
        .o_last_row  (last_row)
    );

    // Input register: refilled whenever its pixel moves on or it is empty
    assign i_pix.ready = advance || !r_pix_vld;
    assign step        = r_pix_vld && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_vld <= 1'b0;
        end else if (i_pix.valid && i_pix.ready) begin
            r_pix_vld <= 1'b1;
        end else if (step) begin
            r_pix_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_pix <= i_pix.gray_pixel;
        end
    end

    btb_track #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pixel     (r_pix),
        .i_threshold (threshold),
        .i_last_col  (last_col),
        .i_last_row  (last_row),
        .o_flags     (flags),
        .o_min_col   (min_col),
        .o_max_col   (max_col),
        .o_min_row   (min_row),
        .o_max_row   (max_row)
    );

    btb_box #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_flags   (flags),
        .i_min_col (min_col),
        .i_max_col (max_col),
        .i_min_row (min_row),
        .i_max_row (max_row),
        .i_edge_en (edge_en),
        .i_frame_w (frame_w),
        .i_frame_h (frame_h),
        .o_advance (advance),
        .o_box     (o_box)
    );

endmodule

`default_nettype wire
